// File: src/chacha20_stream_xor_assert.svh
// ---------------------------------------------------------------------------
// chacha20_stream_xor_assert.svh
// Assertion macros shared by the stream XOR unit. Each macro expands to one
// labeled concurrent assertion clocked by clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_ASSERT_SVH
`define CHACHA20_STREAM_XOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CC20SX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CC20SX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cc20sx_pkg.sv
// ---------------------------------------------------------------------------
// cc20sx_pkg
// Types, constants and helpers shared by the ChaCha20 stream XOR unit.
// ---------------------------------------------------------------------------
package cc20sx_pkg;

  // Field widths of the stream channels.
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 4;
  localparam int CTR_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 64;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_KEY_0    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_1    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_2    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_3    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HI = 3'd5;

  // The "expand 32-byte k" constant words.
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Sixteen-word cipher state, word 0 in the low bits.
  typedef logic [15:0][31:0] word16_t;

  // Operands of one quarter round.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // Rotate left by a constant amount.
  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

// File: src/cc20sx_qr_lane.sv
// ---------------------------------------------------------------------------
// cc20sx_qr_lane
// One quarter-round lane. It performs half of a quarter round per cycle:
// the first half uses rotations of 16 and 12, the second half 8 and 7.
// ---------------------------------------------------------------------------
module cc20sx_qr_lane
  import cc20sx_pkg::*;
(
  input  qr_t  qr_in,
  input  logic second_half,
  output qr_t  qr_out
);

  logic [31:0] a_sum;
  logic [31:0] d_rot;
  logic [31:0] c_sum;
  logic [31:0] b_rot;

  // Two dependent add, xor and rotate steps.
  always_comb begin
    a_sum = qr_in.a + qr_in.b;
    d_rot = second_half ? rotl(qr_in.d ^ a_sum, 8) : rotl(qr_in.d ^ a_sum, 16);
    c_sum = qr_in.c + d_rot;
    b_rot = second_half ? rotl(qr_in.b ^ c_sum, 7) : rotl(qr_in.b ^ c_sum, 12);
  end

  assign qr_out = '{a: a_sum, b: b_rot, c: c_sum, d: d_rot};

endmodule

// File: src/cc20sx_core.sv
// ---------------------------------------------------------------------------
// cc20sx_core
// Keystream block generator. Four quarter-round lanes work on the columns
// or the diagonals of the state side by side, half a quarter round per
// cycle; a final stage adds the input state word by word.
// ---------------------------------------------------------------------------
module cc20sx_core
  import cc20sx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  word16_t init_state,
  output logic    done,
  output word16_t block
);

  localparam int STEPS = 4 * DOUBLE_ROUNDS;
  localparam int RND_W = $clog2(STEPS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(STEPS - 1);

  logic             busy_r;
  logic             fin_r;
  logic             done_r;
  logic [RND_W-1:0] rnd_r;
  word16_t          init_r;
  word16_t          work_r;
  word16_t          work_nxt;
  word16_t          block_r;
  qr_t [3:0]        lane_in;
  qr_t [3:0]        lane_out;
  logic             diag;

  // Step order per double round: column first half, column second half,
  // diagonal first half, diagonal second half.
  assign diag = rnd_r[1];

  // Route state words to the lanes.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_in[l].a = work_r[l];
      lane_in[l].b = diag ? work_r[4 + ((l + 1) % 4)]  : work_r[4 + l];
      lane_in[l].c = diag ? work_r[8 + ((l + 2) % 4)]  : work_r[8 + l];
      lane_in[l].d = diag ? work_r[12 + ((l + 3) % 4)] : work_r[12 + l];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    cc20sx_qr_lane u_lane (
      .qr_in       (lane_in[g]),
      .second_half (rnd_r[0]),
      .qr_out      (lane_out[g])
    );
  end

  // Write the lane results back to their words.
  always_comb begin
    work_nxt = work_r;
    for (int l = 0; l < 4; l++) begin
      work_nxt[l] = lane_out[l].a;
      if (diag) begin
        work_nxt[4 + ((l + 1) % 4)]  = lane_out[l].b;
        work_nxt[8 + ((l + 2) % 4)]  = lane_out[l].c;
        work_nxt[12 + ((l + 3) % 4)] = lane_out[l].d;
      end else begin
        work_nxt[4 + l]  = lane_out[l].b;
        work_nxt[8 + l]  = lane_out[l].c;
        work_nxt[12 + l] = lane_out[l].d;
      end
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // State words and the final word-wise addition.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      init_r <= init_state;
      work_r <= init_state;
    end else if (busy_r) begin
      work_r <= work_nxt;
    end
    if (fin_r) begin
      for (int w = 0; w < 16; w++) begin
        block_r[w] <= work_r[w] + init_r[w];
      end
    end
  end

  assign done  = done_r;
  assign block = block_r;

endmodule

// File: src/chacha20_stream_xor.sv
// ---------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 stream XOR, 96-bit nonce form, up to eight bytes per transfer.
// An item passes the idle, XOR and output states before its result is registered;
// when the current block does not cover it, a new block is generated in the
// generate state between XOR passes, once more if the bytes span two blocks.
// The unit takes no new item until the last one's result has been registered,
// and the output state waits while the result side holds an earlier result.
// Reset: synchronous, active low; config registers, counter, nonce word and output valid clear.
// ---------------------------------------------------------------------------
`include "chacha20_stream_xor_assert.svh"

module chacha20_stream_xor
  import cc20sx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS  = 10,
  parameter int BYTES_PER_ITEM = 8
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [103:0]         in_tdata,   // data_bytes, byte_count, start_counter
  input  logic                 in_tuser,   // message_start
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // cipher_bytes, valid_bytes
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_XOR  = 4'b0010,
    ST_GEN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] BPI = CNT_W'(BYTES_PER_ITEM);
  localparam logic [6:0]       BLOCK_BYTES = 7'd64;

  // Configuration registers.
  logic [3:0][63:0]  key_r;
  logic [63:0]       nonce_lo_r;
  logic [31:0]       nonce_hi_r;

  // Control and payload state.
  state_t            state_r, state_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic [31:0]       n0_r, n0_nxt;
  logic [6:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [7:0][7:0]   data_r, data_nxt;
  logic [7:0][7:0]   ksw_r, ksw_nxt;
  logic [63:0][7:0]  ks_r, ks_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0][7:0]   out_cipher_r, out_cipher_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic              core_start;
  logic              core_done;
  word16_t           core_block;
  word16_t           init_state;
  logic [CNT_W-1:0]  in_count;
  logic [CNT_W-1:0]  need;
  logic [6:0]        avail;
  logic [CNT_W-1:0]  take;
  logic [CNT_W-1:0]  off;
  logic [7:0][7:0]   ks_lo;
  logic [7:0][7:0]   result;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_0:    key_r[0]   <= cfg_wdata;
        REG_KEY_1:    key_r[1]   <= cfg_wdata;
        REG_KEY_2:    key_r[2]   <= cfg_wdata;
        REG_KEY_3:    key_r[3]   <= cfg_wdata;
        REG_NONCE_LO: nonce_lo_r <= cfg_wdata;
        REG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Input state of the next block.
  always_comb begin
    init_state[0]  = SIGMA_0;
    init_state[1]  = SIGMA_1;
    init_state[2]  = SIGMA_2;
    init_state[3]  = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_state[4 + 2 * k] = key_r[k][31:0];
      init_state[5 + 2 * k] = key_r[k][63:32];
    end
    init_state[12] = ctr_r;
    init_state[13] = n0_r;
    init_state[14] = nonce_lo_r[63:32];
    init_state[15] = nonce_hi_r;
  end

  cc20sx_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (core_start),
    .init_state (init_state),
    .done       (core_done),
    .block      (core_block)
  );

  // Byte count saturates at the lane count.
  assign in_count = (in_tdata[67:64] > BPI) ? BPI : in_tdata[67:64];

  // Bytes taken in this pass: what the item still needs, up to what is left.
  assign need  = cnt_r - done_r;
  assign avail = BLOCK_BYTES - pos_r;
  assign take  = (avail < {3'b000, need}) ? avail[CNT_W-1:0] : need;
  assign ks_lo = ks_r[7:0];

  // Merge keystream bytes into the data lanes; lanes beyond the count are zero.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      result[j] = (CNT_W'(j) < cnt_r) ? (data_r[j] ^ ksw_r[j]) : 8'h00;
    end
  end

  // Item sequencer.
  always_comb begin
    state_nxt      = state_r;
    ctr_nxt        = ctr_r;
    n0_nxt         = n0_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    done_nxt       = done_r;
    data_nxt       = data_r;
    ksw_nxt        = ksw_r;
    ks_nxt         = ks_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cipher_nxt = out_cipher_r;
    out_cnt_nxt    = out_cnt_r;
    core_start     = 1'b0;
    off            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          data_nxt  = in_tdata[63:0];
          cnt_nxt   = in_count;
          done_nxt  = '0;
          ksw_nxt   = '0;
          if (in_tuser) begin
            ctr_nxt = in_tdata[99:68];
            n0_nxt  = nonce_lo_r[31:0];
            pos_nxt = BLOCK_BYTES;
          end
          state_nxt = ST_XOR;
        end
      end
      ST_XOR: begin
        if (done_r == cnt_r) begin
          state_nxt = ST_OUT;
        end else if (pos_r == BLOCK_BYTES) begin
          core_start = 1'b1;
          state_nxt  = ST_GEN;
        end else begin
          for (int j = 0; j < BYTES_PER_ITEM; j++) begin
            off = CNT_W'(j) - done_r;
            if ((CNT_W'(j) >= done_r) && (CNT_W'(j) < done_r + take)) begin
              ksw_nxt[j] = ks_lo[off[2:0]];
            end
          end
          ks_nxt   = ks_r >> {take, 3'b000};
          pos_nxt  = pos_r + {3'b000, take};
          done_nxt = done_r + take;
        end
      end
      ST_GEN: begin
        if (core_done) begin
          ks_nxt  = core_block;
          pos_nxt = '0;
          ctr_nxt = ctr_r + 1'b1;
          if (&ctr_r) begin
            n0_nxt = n0_r + 1'b1;
          end
          state_nxt = ST_XOR;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_cipher_nxt = result;
          out_cnt_nxt    = cnt_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= '0;
      n0_r        <= '0;
      pos_r       <= BLOCK_BYTES;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      n0_r        <= n0_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    done_r       <= done_nxt;
    data_r       <= data_nxt;
    ksw_r        <= ksw_nxt;
    ks_r         <= ks_nxt;
    out_cipher_r <= out_cipher_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_cipher_r};

  // Checks on the sequencer.
  `CC20SX_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= BLOCK_BYTES, "byte position beyond block")
  `CC20SX_ASSERT_NOW(a_start_in_xor, core_start, state_r == ST_XOR, "block start outside XOR")
  `CC20SX_ASSERT_NEXT(a_gen_fresh, state_r == ST_GEN && core_done, pos_r == 7'd0,
                      "new block did not reset byte position")
  `CC20SX_ASSERT_NEXT(a_accept_xor, in_tvalid && in_tready, state_r == ST_XOR,
                      "accepted item did not enter XOR")

endmodule

// File: tb/tb_chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// tb_chacha20_stream_xor
// Self-checking testbench for the ChaCha20 stream XOR unit. A behavioral
// keystream generator inside the bench predicts every cipher transfer. The
// checker compares each result with the oldest prediction, byte count included.
// Directed tests cover items sent without a message start after reset, a
// counter wrap that carries into nonce word zero, key changes in the middle of
// a message, ignored register indexes, and zero and oversized byte counts.
// Random phases follow: mostly well-formed messages with some noise items, under
// several key and nonce settings, with random stalls on both sides but in one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chacha20_stream_xor;
  import cc20sx_pkg::*;

  localparam int DBL_ROUNDS     = 10;
  localparam int LANES_PER_ITEM = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 102;
  localparam int MAX_REPORTS    = 10;

  // Register indexes that do not map to any register.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  // One expected result transfer.
  typedef struct packed {
    logic [63:0] cipher;
    logic [3:0]  nbytes;
  } xor_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [103:0]         in_tdata = '0;   // data_bytes, byte_count, start_counter
  logic                 in_tuser = 1'b0; // message_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [71:0]          out_tdata;       // cipher_bytes, valid_bytes
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Register copies and keystream state of the predictor.
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg;
  logic [31:0] nonce_hi_reg;
  logic [31:0] blk_ctr;
  logic [31:0] nonce_w0;
  word16_t     ks_words;
  int          ks_pos;

  xor_result_t pending_cipher [$];
  xor_result_t head;

  bit gaps_on = 1'b1;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int blocks_made = 0;
  int settings_used = 0;

  logic [REG_IDX_W-1:0] reg_list [6] = '{REG_KEY_0, REG_KEY_1, REG_KEY_2,
                                         REG_KEY_3, REG_NONCE_LO, REG_NONCE_HI};

  chacha20_stream_xor #(
    .DOUBLE_ROUNDS (DBL_ROUNDS),
    .BYTES_PER_ITEM(LANES_PER_ITEM)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, set far above the slowest correct run.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    logic [63:0] twice;
    twice = {v, v} << n;
    return twice[63:32];
  endfunction

  // One quarter round on four words.
  function automatic qr_t quarter_mix(input qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rol32(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rol32(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rol32(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rol32(r.b ^ r.c, 7);
    return r;
  endfunction

  // Full keystream block from the current key and nonce registers.
  function automatic word16_t chacha_block(input logic [31:0] ctr, input logic [31:0] n0);
    logic [31:0] init [16];
    logic [31:0] w [16];
    word16_t res;
    qr_t q;
    int a, b, c, d, jj;
    init[0]  = SIGMA_0;
    init[1]  = SIGMA_1;
    init[2]  = SIGMA_2;
    init[3]  = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = key_reg[k][31:0];
      init[5 + 2 * k] = key_reg[k][63:32];
    end
    init[12] = ctr;
    init[13] = n0;
    init[14] = nonce_lo_reg[63:32];
    init[15] = nonce_hi_reg;
    for (int i = 0; i < 16; i++) w[i] = init[i];
    for (int r = 0; r < DBL_ROUNDS; r++) begin
      // Four column rounds, then four diagonal rounds.
      for (int j = 0; j < 8; j++) begin
        jj = j % 4;
        a = jj;
        if (j < 4) begin
          b = 4 + jj; c = 8 + jj; d = 12 + jj;
        end else begin
          b = 4 + (jj + 1) % 4; c = 8 + (jj + 2) % 4; d = 12 + (jj + 3) % 4;
        end
        q = '{a: w[a], b: w[b], c: w[c], d: w[d]};
        q = quarter_mix(q);
        w[a] = q.a; w[b] = q.b; w[c] = q.c; w[d] = q.d;
      end
    end
    for (int i = 0; i < 16; i++) res[i] = w[i] + init[i];
    return res;
  endfunction

  // Predicts the cipher transfer of one input item and advances the state.
  function automatic xor_result_t keystream_xor(input logic [63:0] data,
      input logic [3:0] cnt, input logic start, input logic [31:0] ctr);
    xor_result_t r;
    logic [31:0] wd;
    int n;
    if (start) begin
      blk_ctr  = ctr;
      nonce_w0 = nonce_lo_reg[31:0];
      ks_pos   = 64;
    end
    n = (cnt > LANES_PER_ITEM) ? LANES_PER_ITEM : int'(cnt);
    r.cipher = '0;
    r.nbytes = 4'(n);
    for (int i = 0; i < n; i++) begin
      if (ks_pos >= 64) begin
        ks_words = chacha_block(blk_ctr, nonce_w0);
        blk_ctr = blk_ctr + 32'd1;
        if (blk_ctr == 32'd0) nonce_w0 = nonce_w0 + 32'd1;
        ks_pos = 0;
        blocks_made++;
      end
      wd = ks_words[ks_pos >> 2];
      r.cipher[i * 8 +: 8] = data[i * 8 +: 8] ^ wd[(ks_pos & 3) * 8 +: 8];
      ks_pos++;
    end
    return r;
  endfunction

  // Register write; the unit must be idle.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_KEY_0:    key_reg[0] = val;
      REG_KEY_1:    key_reg[1] = val;
      REG_KEY_2:    key_reg[2] = val;
      REG_KEY_3:    key_reg[3] = val;
      REG_NONCE_LO: nonce_lo_reg = val;
      REG_NONCE_HI: nonce_hi_reg = val[31:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one item, at times after a random gap while gaps are enabled.
  task automatic send_item(input logic [63:0] data, input logic [3:0] cnt,
      input logic start, input logic [31:0] ctr);
    xor_result_t r;
    if (gaps_on && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, ctr, cnt, data};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    r = keystream_xor(data, cnt, start, ctr);
    pending_cipher.push_back(r);
    items_sent++;
  endtask

  // Holds off the sender until every expected result has arrived.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 4'd8;
    if (r < 85) return 4'($urandom_range(1, 7));
    if (r < 92) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic logic [31:0] pick_counter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 75) return 32'd0;
    return 32'hffff_ffff - 32'($urandom_range(0, 3));
  endfunction

  // Items without a message start run from counter zero and nonce word zero.
  task automatic test_no_start_after_reset();
    gaps_on = 1'b1;
    cfg_write(REG_KEY_0, 64'hffff_ffff_ffff_ffff);
    cfg_write(REG_KEY_1, 64'h0);
    cfg_write(REG_KEY_2, rand64());
    cfg_write(REG_KEY_3, 64'h0f1e_2d3c_4b5a_6978);
    cfg_write(REG_NONCE_LO, 64'h0123_4567_89ab_cdef);
    cfg_write(REG_NONCE_HI, 64'hffff_ffff_8000_0001);
    settings_used++;
    send_item(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 32'hffff_ffff);
    send_item(64'h0, 4'd8, 1'b0, 32'h0);
    send_item(rand64(), 4'd15, 1'b0, $urandom);
    send_item(rand64(), 4'd0, 1'b0, $urandom);
    send_item(rand64(), 4'd1, 1'b0, $urandom);
    send_item(rand64(), 4'd9, 1'b0, $urandom);
    drain();
  endtask

  // The block counter wraps and carries into nonce word zero.
  task automatic test_counter_wrap();
    cfg_write(REG_NONCE_LO, {$urandom, 32'hffff_ffff});
    settings_used++;
    send_item(rand64(), 4'd8, 1'b1, 32'hffff_ffff);
    repeat (8) send_item(rand64(), 4'd8, 1'b0, $urandom);
    drain();
  endtask

  // A key change mid-message takes effect at the next block; unused
  // register indexes change nothing.
  task automatic test_rekey_midstream();
    cfg_write(REG_KEY_0, rand64());
    cfg_write(REG_NONCE_HI, {32'h0, $urandom});
    cfg_write(REG_UNUSED_6, 64'hffff_ffff_ffff_ffff);
    cfg_write(REG_UNUSED_7, 64'hffff_ffff_ffff_ffff);
    settings_used++;
    repeat (8) send_item(rand64(), 4'd8, 1'b0, $urandom);
    drain();
  endtask

  // Zero counts change no state except the load of a message start.
  task automatic test_zero_count();
    send_item(rand64(), 4'd0, 1'b1, 32'd5);
    send_item(rand64(), 4'd3, 1'b0, 32'h0);
    send_item(rand64(), 4'd0, 1'b0, 32'h0);
    send_item(rand64(), 4'd5, 1'b1, 32'h8000_0000);
    drain();
  endtask

  // Random messages under several register settings.
  task automatic test_random_messages();
    int sent;
    int len;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // New register setting: all zeros, all ones, then random.
      for (int i = 0; i < 6; i++) begin
        if (p == 0) cfg_write(reg_list[i], 64'h0);
        else if (p == 1) cfg_write(reg_list[i], 64'hffff_ffff_ffff_ffff);
        else if ($urandom_range(0, 1) == 1) cfg_write(reg_list[i], rand64());
      end
      if (p > 1 && $urandom_range(0, 2) == 0)
        cfg_write(REG_NONCE_LO, {$urandom, 32'hffff_ffff});
      settings_used++;
      // One phase runs with no idling on either side.
      gaps_on = (p != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) != 0) begin
          len = $urandom_range(1, 24);
          if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
          send_item(rand64(), pick_count(), 1'b1, pick_counter());
          for (int k = 1; k < len; k++) send_item(rand64(), pick_count(), 1'b0, $urandom);
          sent += len;
        end else begin
          send_item(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom);
          sent++;
        end
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    out_tready <= gaps_on ? ($urandom_range(0, 99) >= 38) : 1'b1;
  end

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_cipher.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: cipher %h bytes %0d", out_tdata[63:0], out_tdata[67:64]);
      end else begin
        head = pending_cipher.pop_front();
        if (out_tdata[63:0] !== head.cipher || out_tdata[67:64] !== head.nbytes) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: expected cipher %h bytes %0d, got cipher %h bytes %0d",
                     head.cipher, head.nbytes, out_tdata[63:0], out_tdata[67:64]);
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    nonce_lo_reg = '0;
    nonce_hi_reg = '0;
    blk_ctr      = '0;
    nonce_w0     = '0;
    ks_words     = '0;
    ks_pos       = 64;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_start_after_reset();
    test_counter_wrap();
    test_rekey_midstream();
    test_zero_count();
    test_random_messages();

    drain();
    repeat (60) @(posedge clk);
    if (pending_cipher.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pending_cipher.size());
    end
    $display("Sent %0d items and checked %0d results over %0d keystream blocks.",
             items_sent, results_seen, blocks_made);
    $display("Used %0d register settings; %0d mismatches in total.",
             settings_used, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: chacha20_stream_xor.f
+incdir+src
src/cc20sx_pkg.sv
src/cc20sx_qr_lane.sv
src/cc20sx_core.sv
src/chacha20_stream_xor.sv
tb/tb_chacha20_stream_xor.sv
